@@ design/ssmcs_pkg.sv @@
// Shared types, codes and chip-type tables for the SPI save-memory command sequencer.
package ssmcs_pkg;

	localparam int unsigned MAX_REQUEST_BYTES = 256;

	localparam logic [3:0] TYPE_EEP512  = 4'd0;
	localparam logic [3:0] TYPE_EEP128K = 4'd3;
	localparam logic [3:0] TYPE_FLASH_LO = 4'd4;
	localparam logic [3:0] TYPE_FLASH_HI = 4'd7;
	localparam logic [3:0] TYPE_UNKNOWN = 4'd9;

	localparam logic [1:0] MODE_READ  = 2'd0;
	localparam logic [1:0] MODE_WRITE = 2'd1;
	localparam logic [1:0] MODE_ERASE = 2'd2;
	localparam logic [1:0] MODE_NONE  = 2'd3;

	localparam logic [1:0] DIR_NONE  = 2'd0;
	localparam logic [1:0] DIR_WRITE = 2'd1;
	localparam logic [1:0] DIR_READ  = 2'd2;

	localparam logic [7:0] OP_READ  = 8'h03;
	localparam logic [7:0] OP_WRITE = 8'h02;
	localparam logic [7:0] OP_ERASE = 8'hD8;

	localparam logic [11:0] WRITE_POLL_MS = 12'd50;
	localparam logic [11:0] ERASE_POLL_MS = 12'd3000;

	typedef struct packed {
		logic [1:0]  mode;
		logic [22:0] start_address;
		logic [8:0]  byte_count;
	} req_t;

	typedef struct packed {
		logic        status;
		logic [7:0]  command_byte;
		logic [7:0]  first_address_byte;
		logic [7:0]  second_address_byte;
		logic [7:0]  third_address_byte;
		logic [1:0]  address_bytes;
		logic [7:0]  data_offset;
		logic [8:0]  data_length;
		logic [1:0]  data_direction;
		logic        write_enable_first;
		logic [11:0] busy_timeout_ms;
		logic        last;
	} desc_t;

	typedef struct packed {
		logic [7:0] cmd;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [7:0] b3;
		logic [1:0] nbytes;
	} enc_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_EMIT
	} state_t;

	function automatic logic is_flash(input logic [3:0] t);
		return (t >= TYPE_FLASH_LO) && (t <= TYPE_FLASH_HI);
	endfunction

	// Capacity in bytes; zero for unknown types.
	function automatic logic [23:0] capacity(input logic [3:0] t);
		logic [23:0] c;
		unique case (t)
			4'd0: c = 24'd512;
			4'd1: c = 24'd8192;
			4'd2: c = 24'd65536;
			4'd3: c = 24'd131072;
			4'd4: c = 24'd262144;
			4'd5: c = 24'd524288;
			4'd6: c = 24'd1048576;
			4'd7: c = 24'd8388608;
			4'd8: c = 24'd32768;
			default: c = 24'd0;
		endcase
		return c;
	endfunction

	// Page size in bytes; zero means no page limit.
	function automatic logic [8:0] page_bytes(input logic [3:0] t);
		logic [8:0] p;
		unique case (t)
			4'd0: p = 9'd16;
			4'd1: p = 9'd32;
			4'd2, 4'd3: p = 9'd128;
			4'd4, 4'd5, 4'd6, 4'd7: p = 9'd256;
			default: p = 9'd0;
		endcase
		return p;
	endfunction

	// Command byte and address bytes in the type's transmit format.
	function automatic enc_t encode(input logic [3:0] t, input logic [7:0] op,
			input logic [22:0] a);
		enc_t e;
		e = '0;
		e.cmd = op;
		if (t == TYPE_EEP512) begin
			e.cmd[3] = e.cmd[3] | a[8];
			e.b1 = a[7:0];
			e.nbytes = 2'd1;
		end else if (is_flash(t)) begin
			e.b1 = {1'b0, a[22:16]};
			e.b2 = a[15:8];
			e.b3 = a[7:0];
			e.nbytes = 2'd3;
		end else begin
			if (t == TYPE_EEP128K) begin
				e.cmd[3] = e.cmd[3] | a[16];
			end
			e.b1 = a[15:8];
			e.b2 = a[7:0];
			e.nbytes = 2'd2;
		end
		return e;
	endfunction

endpackage

@@ design/spi_save_memory_command_sequencer.sv @@
// Top level of the SPI save-memory command sequencer: request check and chunk sequencer.
//
// Usage: one request (read, write or sector erase, start address, byte count) is taken
// on the in channel (in_valid / in_stall / in_data) and turned into SPI transaction
// descriptors on the out channel (out_valid / out_stall / out_data). The chip type comes
// from the save_type register, written through cfg_wen / cfg_wdata; the user must write
// it only while the block idles, which the block does not enforce. Timing: the request
// is checked and its length clamped in the cycle after the transfer. A rejected request,
// a read or an erase then gives one descriptor, loaded from the check state once the
// output slot is free. A write is cut at page boundaries by one shared address adder and
// page-room subtractor, one chunk per cycle while the receiver does not stall, its first
// descriptor coming from the emit state; a write gives up to 17 descriptors.
// in_stall is high from the transfer until the last descriptor sits in the output
// register. A stalled receiver holds the output register and the chunk sequencer with
// it; the descriptor on out_data does not change while stalled.
// Reset: arst_n clears the sequencer and the output valid at once and sets save_type
// to unknown, so every request is rejected until a type is written.
module spi_save_memory_command_sequencer
	import ssmcs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wen,
	input  logic [3:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_stall,
	input  req_t       in_data,
	output logic       out_valid,
	input  logic       out_stall,
	output desc_t      out_data
);

	state_t      state_q, state_d;
	logic [3:0]  save_type_q;
	logic [1:0]  mode_q;
	logic [22:0] addr_q;
	logic [8:0]  count_q;
	logic [8:0]  len_q;
	logic [8:0]  off_q;
	logic        out_valid_q;
	desc_t       out_data_q;

	// combinational datapath
	logic        slot_free;
	logic        reject;
	logic [23:0] cap;
	logic [23:0] room_cap;
	logic [8:0]  cnt_clamp;
	logic [8:0]  len_calc;
	logic [22:0] chunk_addr;
	logic [8:0]  rem;
	logic [8:0]  page;
	logic [8:0]  page_room;
	logic [8:0]  chunk;
	logic [8:0]  off_next;
	logic        chunk_last;
	logic [7:0]  enc_op;
	logic [22:0] enc_addr;
	enc_t        enc;
	logic        load_out;
	logic        load_len;
	logic        adv_off;
	desc_t       desc_next;

	assign slot_free = !out_valid_q || !out_stall;

	// Request check and length clamp.
	always_comb begin
		cap = capacity(save_type_q);
		reject = (save_type_q >= TYPE_UNKNOWN) || (mode_q == MODE_NONE)
			|| ((mode_q != MODE_ERASE) && (count_q == 9'd0))
			|| ({1'b0, addr_q} >= cap)
			|| ((mode_q == MODE_ERASE) && !is_flash(save_type_q));
		room_cap = cap - {1'b0, addr_q};
		cnt_clamp = (count_q > 9'(MAX_REQUEST_BYTES)) ? 9'(MAX_REQUEST_BYTES) : count_q;
		len_calc = ({15'd0, cnt_clamp} > room_cap) ? room_cap[8:0] : cnt_clamp;
	end

	// Shared chunk unit: current address, bytes left, room to the page end.
	always_comb begin
		chunk_addr = addr_q + {14'd0, off_q};
		rem = len_q - off_q;
		page = page_bytes(save_type_q);
		page_room = page - (chunk_addr[8:0] & (page - 9'd1));
		chunk = ((page != 9'd0) && (rem > page_room)) ? page_room : rem;
		off_next = off_q + chunk;
		chunk_last = (off_next >= len_q);
	end

	// One address encoder, fed from the chunk in the emit state, the request otherwise.
	always_comb begin
		enc_addr = (state_q == ST_EMIT) ? chunk_addr : addr_q;
		priority if (state_q == ST_EMIT) begin
			enc_op = OP_WRITE;
		end else if (mode_q == MODE_ERASE) begin
			enc_op = OP_ERASE;
		end else begin
			enc_op = OP_READ;
		end
		enc = encode(save_type_q, enc_op, enc_addr);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (!reject && (mode_q == MODE_WRITE)) begin
					state_d = ST_EMIT;
				end else if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (slot_free && chunk_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs and the descriptor to load.
	always_comb begin
		load_out = 1'b0;
		load_len = 1'b0;
		adv_off = 1'b0;
		desc_next = '0;
		unique case (state_q)
			ST_IDLE: begin
			end
			ST_CHECK: begin
				desc_next.last = 1'b1;
				if (reject) begin
					desc_next.status = 1'b1;
					load_out = slot_free;
				end else if (mode_q == MODE_WRITE) begin
					load_len = 1'b1;
				end else begin
					desc_next.command_byte = enc.cmd;
					desc_next.first_address_byte = enc.b1;
					desc_next.second_address_byte = enc.b2;
					desc_next.third_address_byte = enc.b3;
					desc_next.address_bytes = enc.nbytes;
					if (mode_q == MODE_ERASE) begin
						desc_next.write_enable_first = 1'b1;
						desc_next.busy_timeout_ms = ERASE_POLL_MS;
					end else begin
						desc_next.data_length = len_calc;
						desc_next.data_direction = DIR_READ;
					end
					load_out = slot_free;
				end
			end
			ST_EMIT: begin
				desc_next.command_byte = enc.cmd;
				desc_next.first_address_byte = enc.b1;
				desc_next.second_address_byte = enc.b2;
				desc_next.third_address_byte = enc.b3;
				desc_next.address_bytes = enc.nbytes;
				desc_next.data_offset = off_q[7:0];
				desc_next.data_length = chunk;
				desc_next.data_direction = DIR_WRITE;
				desc_next.write_enable_first = 1'b1;
				desc_next.busy_timeout_ms = WRITE_POLL_MS;
				desc_next.last = chunk_last;
				load_out = slot_free;
				adv_off = slot_free;
			end
			default: begin
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			save_type_q <= TYPE_UNKNOWN;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wen) begin
				save_type_q <= cfg_wdata;
			end
			// Hold the descriptor until the receiver takes it; refill in the same cycle.
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && in_valid) begin
			mode_q <= in_data.mode;
			addr_q <= in_data.start_address;
			count_q <= in_data.byte_count;
		end
		if (load_len) begin
			len_q <= len_calc;
			off_q <= 9'd0;
		end else if (adv_off) begin
			off_q <= off_next;
		end
		if (load_out) begin
			out_data_q <= desc_next;
		end
	end

	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	// A rejected request ends with its single descriptor.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status |-> out_data.last)
		else $error("rejected descriptor without last");

	// The chunk sequencer never runs past the clamped length.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> (off_q < len_q) && (len_q != 9'd0))
		else $error("chunk offset beyond request length");

	// Every write chunk carries data and is no larger than one page.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> (chunk != 9'd0) && ((page == 9'd0) || (chunk <= page)))
		else $error("bad write chunk size");

	// A new descriptor is loaded only into a free output slot.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall && (state_q != ST_IDLE) |=> $stable(out_data))
		else $error("held descriptor overwritten");

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the SPI save-memory command sequencer.
module testbench;
	import ssmcs_pkg::*;

	// Chip-type codes of the save_type register. The package names only the few the RTL needs.
	localparam logic [3:0] CHIP_EEP512    = TYPE_EEP512;
	localparam logic [3:0] CHIP_EEP8K     = 4'd1;
	localparam logic [3:0] CHIP_EEP64K    = 4'd2;
	localparam logic [3:0] CHIP_EEP128K   = TYPE_EEP128K;
	localparam logic [3:0] CHIP_FLASH256K = TYPE_FLASH_LO;
	localparam logic [3:0] CHIP_FLASH512K = 4'd5;
	localparam logic [3:0] CHIP_FLASH1M   = 4'd6;
	localparam logic [3:0] CHIP_FLASH8M   = TYPE_FLASH_HI;
	localparam logic [3:0] CHIP_FRAM32K   = 4'd8;
	localparam logic [3:0] CHIP_UNKNOWN   = TYPE_UNKNOWN;

	localparam int unsigned ADDR_SPAN   = 32'h0080_0000;
	localparam int          HOLD_CYCLES = 120;
	localparam int          LIMIT_CYCLES = 400000;

	// One row of the directed plan: chip type to run under, the request, and, where it is
	// obvious, the single descriptor it must give.
	typedef struct {
		logic [3:0] chip;
		req_t       req;
		bit         typed;
		desc_t      want;
	} plan_row_t;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  cfg_wen = 1'b0;
	logic  [3:0] cfg_wdata = 4'd0;
	logic  in_valid = 1'b0;
	logic  in_stall;
	req_t  in_data = '0;
	logic  out_valid;
	logic  out_stall = 1'b0;
	desc_t out_data;

	logic [3:0] chip_type = CHIP_UNKNOWN;  // the register as the predictor sees it
	desc_t      due_descs [$];             // descriptors owed by the block, oldest first
	plan_row_t  directed_plan [$];
	desc_t      rejected;
	int         mismatch_count = 0;
	int         burst_left = 0;
	int         cycle_count = 0;
	bit         steady = 1'b0;             // no gaps and no stalls on either side
	bit         hold_off_req = 1'b0;       // ask the receiver for one long hold-off

	spi_save_memory_command_sequencer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Capacity in bytes of each chip type; zero marks an unknown type.
	function automatic int unsigned chip_bytes(input logic [3:0] t);
		case (t)
			CHIP_EEP512:    return 512;
			CHIP_EEP8K:     return 8192;
			CHIP_EEP64K:    return 65536;
			CHIP_EEP128K:   return 131072;
			CHIP_FLASH256K: return 262144;
			CHIP_FLASH512K: return 524288;
			CHIP_FLASH1M:   return 1048576;
			CHIP_FLASH8M:   return 8388608;
			CHIP_FRAM32K:   return 32768;
			default:        return 0;
		endcase
	endfunction

	// Write page of each chip type; zero means the whole request goes in one chunk.
	function automatic int unsigned chip_page(input logic [3:0] t);
		case (t)
			CHIP_EEP512:                  return 16;
			CHIP_EEP8K:                   return 32;
			CHIP_EEP64K, CHIP_EEP128K:    return 128;
			CHIP_FLASH256K, CHIP_FLASH512K,
			CHIP_FLASH1M, CHIP_FLASH8M:   return 256;
			default:                      return 0;
		endcase
	endfunction

	function automatic bit chip_is_flash(input logic [3:0] t);
		return t >= CHIP_FLASH256K && t <= CHIP_FLASH8M;
	endfunction

	// Command byte and address bytes for address a, every other field cleared.
	function automatic desc_t address_fields(input logic [3:0] t, input logic [7:0] op,
			input logic [22:0] a);
		desc_t d;
		d = '0;
		d.command_byte = op;
		if (t == CHIP_EEP512) begin
			// A8 rides in command bit 3
			d.command_byte = op | {4'd0, a[8], 3'd0};
			d.first_address_byte = a[7:0];
			d.address_bytes = 2'd1;
		end else if (chip_is_flash(t)) begin
			d.first_address_byte = {1'b0, a[22:16]};
			d.second_address_byte = a[15:8];
			d.third_address_byte = a[7:0];
			d.address_bytes = 2'd3;
		end else begin
			// A16 rides in command bit 3 on the 128K part only
			if (t == CHIP_EEP128K)
				d.command_byte = op | {4'd0, a[16], 3'd0};
			d.first_address_byte = a[15:8];
			d.second_address_byte = a[7:0];
			d.address_bytes = 2'd2;
		end
		return d;
	endfunction

	// Work out the descriptors one request gives and queue them as owed.
	task automatic sequence_request(input req_t req);
		desc_t       d;
		int unsigned cap, len, page, off, a, chunk, room;
		cap = chip_bytes(chip_type);
		if (chip_type >= CHIP_UNKNOWN || req.mode == MODE_NONE
				|| (req.mode != MODE_ERASE && req.byte_count == 0)
				|| req.start_address >= cap
				|| (req.mode == MODE_ERASE && !chip_is_flash(chip_type))) begin
			due_descs.push_back(rejected);
		end else if (req.mode == MODE_ERASE) begin
			// the chip erases the sector that holds the address, so send it unchanged
			d = address_fields(chip_type, OP_ERASE, req.start_address);
			d.write_enable_first = 1'b1;
			d.busy_timeout_ms = ERASE_POLL_MS;
			d.last = 1'b1;
			due_descs.push_back(d);
		end else begin
			len = req.byte_count;
			if (len > MAX_REQUEST_BYTES)
				len = MAX_REQUEST_BYTES;
			if (len > cap - req.start_address)
				len = cap - req.start_address;
			if (req.mode == MODE_READ) begin
				d = address_fields(chip_type, OP_READ, req.start_address);
				d.data_length = len[8:0];
				d.data_direction = DIR_READ;
				d.last = 1'b1;
				due_descs.push_back(d);
			end else begin
				// cut the write at every page boundary
				page = chip_page(chip_type);
				off = 0;
				while (off < len) begin
					a = req.start_address + off;
					chunk = len - off;
					if (page != 0) begin
						room = page - (a % page);
						if (chunk > room)
							chunk = room;
					end
					d = address_fields(chip_type, OP_WRITE, a[22:0]);
					d.data_offset = off[7:0];
					d.data_length = chunk[8:0];
					d.data_direction = DIR_WRITE;
					d.write_enable_first = 1'b1;
					d.busy_timeout_ms = WRITE_POLL_MS;
					off += chunk;
					d.last = off >= len;
					due_descs.push_back(d);
				end
			end
		end
	endtask

	function automatic desc_t single_desc(input logic [7:0] cmd, input logic [7:0] b1,
			input logic [7:0] b2, input logic [7:0] b3, input logic [1:0] nbytes,
			input logic [8:0] len, input logic [1:0] dir, input logic wen,
			input logic [11:0] poll);
		desc_t d;
		d = '0;
		d.command_byte = cmd;
		d.first_address_byte = b1;
		d.second_address_byte = b2;
		d.third_address_byte = b3;
		d.address_bytes = nbytes;
		d.data_length = len;
		d.data_direction = dir;
		d.write_enable_first = wen;
		d.busy_timeout_ms = poll;
		d.last = 1'b1;
		return d;
	endfunction

	function automatic plan_row_t plan_row(input logic [3:0] chip, input logic [1:0] mode,
			input int unsigned addr, input int unsigned count, input bit typed,
			input desc_t want);
		plan_row_t r;
		r.chip = chip;
		r.req.mode = mode;
		r.req.start_address = addr[22:0];
		r.req.byte_count = count[8:0];
		r.typed = typed;
		r.want = want;
		return r;
	endfunction

	// Offer one request and hold it until the block takes it; the sender runs in bursts
	// with random gaps between them. Called and left at a falling edge.
	task automatic send_request(input req_t req, input bit typed, input desc_t want);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = steady ? 0 : $urandom_range(0, 6);
			repeat (gap) @(negedge clk);
		end
		in_data = req;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		// the transfer happened at this edge
		if (typed)
			due_descs.push_back(want);
		else
			sequence_request(req);
		burst_left--;
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	// Change the chip type only once the block has given every owed descriptor.
	task automatic write_save_type(input logic [3:0] t);
		while (due_descs.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		cfg_wen = 1'b1;
		cfg_wdata = t;
		@(negedge clk);
		cfg_wen = 1'b0;
		chip_type = t;
	endtask

	// Random requests under one chip type: mostly well-formed reads, writes and erases
	// aimed inside the chip, a share near its top end and beyond it, and some noise.
	task automatic run_random_phase(input logic [3:0] chip, input int n_items,
			input int drain_at, input int hold_at);
		req_t        req;
		int unsigned span, pick, sel;
		desc_t       none;
		none = '0;
		write_save_type(chip);
		span = chip_bytes(chip);
		if (span == 0)
			span = ADDR_SPAN;
		for (int k = 0; k < n_items; k++) begin
			// pause until the block has drained completely
			if (k == drain_at)
				while (due_descs.size() != 0)
					@(negedge clk);
			// hold the receiver off while requests keep coming, so the block backs up
			if (k == hold_at)
				hold_off_req = 1'b1;
			pick = $urandom_range(0, 99);
			if (pick < 45)
				req.mode = MODE_WRITE;
			else if (pick < 72)
				req.mode = MODE_READ;
			else if (pick < 90)
				req.mode = MODE_ERASE;
			else if (pick < 93)
				req.mode = MODE_NONE;
			else
				req.mode = 2'($urandom_range(0, 2));
			sel = $urandom_range(0, 9);
			if (pick >= 93)
				req.start_address = 23'($urandom_range(ADDR_SPAN - 1, 0));
			else if (sel == 0)
				req.start_address = 23'((span < ADDR_SPAN) ?
						$urandom_range(ADDR_SPAN - 1, span) : $urandom_range(ADDR_SPAN - 1, 0));
			else if (sel <= 2)
				req.start_address = 23'(span - $urandom_range(1, (span < 300) ? span : 300));
			else
				req.start_address = 23'($urandom_range(span - 1, 0));
			sel = $urandom_range(0, 19);
			if (sel == 0)
				req.byte_count = 9'd0;
			else if (sel <= 2)
				req.byte_count = 9'd256;
			else if (sel <= 9)
				req.byte_count = 9'($urandom_range(1, 32));
			else
				req.byte_count = 9'($urandom_range(1, 256));
			send_request(req, 1'b0, none);
		end
	endtask

	// Receiver: stall in runs of its own, with long clear stretches, one long hold-off on
	// request and none at all while steady.
	initial begin : receiver
		int  run_left;
		bit  stalling;
		run_left = 0;
		stalling = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				out_stall = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_off_req = 1'b0;
				out_stall = 1'b0;
			end else if (steady) begin
				out_stall = 1'b0;
			end else begin
				if (run_left == 0) begin
					stalling = !stalling;
					if (stalling)
						run_left = $urandom_range(1, 4);
					else
						run_left = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(1, 10);
				end
				out_stall = stalling;
				run_left--;
			end
		end
	end

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			mismatch_count++;
			$display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
		end
	endtask

	// Compare each descriptor transfer with the oldest one owed.
	always @(posedge clk) begin : descriptor_check
		desc_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (due_descs.size() == 0) begin
				mismatch_count++;
				$display("%0t: descriptor with none expected, got 0x%0h", $time, out_data);
			end else begin
				want = due_descs.pop_front();
				check_field("status", want.status, out_data.status);
				check_field("command_byte", want.command_byte, out_data.command_byte);
				check_field("first_address_byte", want.first_address_byte,
						out_data.first_address_byte);
				check_field("second_address_byte", want.second_address_byte,
						out_data.second_address_byte);
				check_field("third_address_byte", want.third_address_byte,
						out_data.third_address_byte);
				check_field("address_bytes", want.address_bytes, out_data.address_bytes);
				check_field("data_offset", want.data_offset, out_data.data_offset);
				check_field("data_length", want.data_length, out_data.data_length);
				check_field("data_direction", want.data_direction, out_data.data_direction);
				check_field("write_enable_first", want.write_enable_first,
						out_data.write_enable_first);
				check_field("busy_timeout_ms", want.busy_timeout_ms, out_data.busy_timeout_ms);
				check_field("last", want.last, out_data.last);
			end
		end
	end

	// Stop a hung run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("** spi_save_memory_command_sequencer: FAILED **");
			$finish;
		end
	end

	initial begin : stimulus
		desc_t none;
		none = '0;
		rejected = '0;
		rejected.status = 1'b1;
		rejected.last = 1'b1;

		// Hold reset from time zero, release on a falling edge.
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// Unknown type straight after reset: everything is rejected.
		directed_plan.push_back(plan_row(CHIP_UNKNOWN, MODE_READ, 0, 1, 1'b1, rejected));
		directed_plan.push_back(plan_row(CHIP_UNKNOWN, MODE_WRITE, ADDR_SPAN - 1, 256, 1'b1,
				rejected));
		// 512-byte EEPROM: A8 folding, clamp at the top, 17-chunk write, every rejection.
		directed_plan.push_back(plan_row(CHIP_EEP512, MODE_READ, 'h1FF, 256, 1'b1,
				single_desc(OP_READ | 8'h08, 8'hFF, 8'h00, 8'h00, 2'd1, 9'd1, DIR_READ,
				1'b0, 12'd0)));
		directed_plan.push_back(plan_row(CHIP_EEP512, MODE_READ, 0, 256, 1'b1,
				single_desc(OP_READ, 8'h00, 8'h00, 8'h00, 2'd1, 9'd256, DIR_READ,
				1'b0, 12'd0)));
		directed_plan.push_back(plan_row(CHIP_EEP512, MODE_WRITE, 'h001, 256, 1'b0, none));
		directed_plan.push_back(plan_row(CHIP_EEP512, MODE_WRITE, 'h0F5, 40, 1'b0, none));
		directed_plan.push_back(plan_row(CHIP_EEP512, MODE_READ, 'h200, 1, 1'b1, rejected));
		directed_plan.push_back(plan_row(CHIP_EEP512, MODE_ERASE, 0, 0, 1'b1, rejected));
		directed_plan.push_back(plan_row(CHIP_EEP512, MODE_READ, 5, 0, 1'b1, rejected));
		directed_plan.push_back(plan_row(CHIP_EEP512, MODE_NONE, 5, 5, 1'b1, rejected));
		// Two-byte EEPROMs: write clamped at the top, write across two page boundaries.
		directed_plan.push_back(plan_row(CHIP_EEP8K, MODE_WRITE, 'h1FE0, 100, 1'b0, none));
		directed_plan.push_back(plan_row(CHIP_EEP64K, MODE_WRITE, 'h007F, 130, 1'b0, none));
		// 128K EEPROM: A16 folding.
		directed_plan.push_back(plan_row(CHIP_EEP128K, MODE_WRITE, 'h1FF80, 256, 1'b0, none));
		directed_plan.push_back(plan_row(CHIP_EEP128K, MODE_READ, 'h10000, 5, 1'b1,
				single_desc(OP_READ | 8'h08, 8'h00, 8'h00, 8'h00, 2'd2, 9'd5, DIR_READ,
				1'b0, 12'd0)));
		// Flash: erase at the last address, out-of-range read, full-size read, top write.
		directed_plan.push_back(plan_row(CHIP_FLASH256K, MODE_READ, 'h40000, 1, 1'b1,
				rejected));
		directed_plan.push_back(plan_row(CHIP_FLASH256K, MODE_ERASE, 'h3FFFF, 0, 1'b1,
				single_desc(OP_ERASE, 8'h03, 8'hFF, 8'hFF, 2'd3, 9'd0, DIR_NONE, 1'b1,
				ERASE_POLL_MS)));
		directed_plan.push_back(plan_row(CHIP_FLASH8M, MODE_ERASE, ADDR_SPAN - 1, 0, 1'b1,
				single_desc(OP_ERASE, 8'h7F, 8'hFF, 8'hFF, 2'd3, 9'd0, DIR_NONE, 1'b1,
				ERASE_POLL_MS)));
		directed_plan.push_back(plan_row(CHIP_FLASH8M, MODE_WRITE, 'h7FFF01, 256, 1'b0, none));
		directed_plan.push_back(plan_row(CHIP_FLASH8M, MODE_READ, 0, 256, 1'b1,
				single_desc(OP_READ, 8'h00, 8'h00, 8'h00, 2'd3, 9'd256, DIR_READ,
				1'b0, 12'd0)));
		// FRAM: one chunk regardless of pages, clamp at the top, no erase.
		directed_plan.push_back(plan_row(CHIP_FRAM32K, MODE_WRITE, 'h7F00, 256, 1'b0, none));
		directed_plan.push_back(plan_row(CHIP_FRAM32K, MODE_WRITE, 'h7FF0, 200, 1'b0, none));
		directed_plan.push_back(plan_row(CHIP_FRAM32K, MODE_ERASE, 0, 0, 1'b1, rejected));
		directed_plan.push_back(plan_row(CHIP_FRAM32K, MODE_READ, 'h8000, 1, 1'b1, rejected));

		foreach (directed_plan[i]) begin
			if (directed_plan[i].chip != chip_type)
				write_save_type(directed_plan[i].chip);
			send_request(directed_plan[i].req, directed_plan[i].typed, directed_plan[i].want);
		end

		// Random part, a phase for each chip type (the 512-byte EEPROM twice), the lowest and highest type codes among them.
		run_random_phase(CHIP_FLASH256K, 13, -1, -1);
		// Hold the receiver off long enough for the block to back up into its input.
		run_random_phase(CHIP_EEP512, 13, -1, 0);
		run_random_phase(CHIP_EEP64K, 13, 8, -1);
		run_random_phase(CHIP_FRAM32K, 13, -1, -1);
		steady = 1'b1;
		run_random_phase(CHIP_FLASH512K, 13, -1, -1);
		steady = 1'b0;
		run_random_phase(CHIP_EEP128K, 13, -1, -1);
		run_random_phase(CHIP_EEP8K, 13, -1, -1);
		run_random_phase(CHIP_FLASH1M, 13, -1, -1);
		run_random_phase(CHIP_FLASH8M, 13, -1, -1);
		run_random_phase(CHIP_UNKNOWN, 13, -1, -1);
		run_random_phase(CHIP_EEP512, 13, -1, -1);

		// Drain, then keep the clock running so that anything spurious shows.
		while (due_descs.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (mismatch_count == 0)
			$display("** spi_save_memory_command_sequencer: PASSED **");
		else
			$display("** spi_save_memory_command_sequencer: FAILED **");
		$finish;
	end

endmodule
